[hw/rtl/a256c_pkg.sv]
// shared types, constants and tables for the aes-256 ctr keystream generator
`timescale 1ns / 1ps
package a256c_pkg;

    localparam int BLOCK_BYTES = 16;
    localparam int ROUNDS      = 14;

    typedef logic [7:0]   byte_t;
    typedef logic [127:0] block_t;

    typedef struct packed {
        logic       restart;
        logic [4:0] request_bytes;
    } in_word_t;

    typedef struct packed {
        logic [63:0] stream_lo;
        logic [63:0] stream_hi;
        logic [4:0]  byte_count;
    } out_word_t;

    // round key write from the key schedule unit
    typedef struct packed {
        logic       we;
        logic       last;
        logic [3:0] idx;
        block_t     data;
    } rk_wr_t;

    typedef enum logic [2:0] {
        CFG_KEY_W0   = 3'd0,
        CFG_KEY_W1   = 3'd1,
        CFG_KEY_W2   = 3'd2,
        CFG_KEY_W3   = 3'd3,
        CFG_NONCE_LO = 3'd4,
        CFG_NONCE_HI = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEYX,
        ST_PREP,
        ST_ENC,
        ST_FINISH
    } state_t;

    localparam byte_t RCON [0:7] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80
    };

    localparam byte_t SBOX [0:255] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
        8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
        8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
        8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
        8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
        8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
        8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
        8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
        8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
        8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
        8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
        8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
        8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
        8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
        8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
        8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
        8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic byte_t xtime(input byte_t b);
        xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

[hw/rtl/a256c_round.sv]
// one aes round: subbytes, shiftrows, mixcolumns (skipped on the last round), addroundkey
`timescale 1ns / 1ps
module a256c_round
    import a256c_pkg::*;
(
    input  block_t st,
    input  block_t rk,
    input  logic   last,
    output block_t res
);

    byte_t t [16];
    byte_t m [16];

    // substitute and rotate rows; byte index is row + 4 * column
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                t[r + 4 * c] = SBOX[st[8 * (r + 4 * ((c + r) % 4)) +: 8]];
            end
        end
    end

    // column mix and key add
    always_comb
    begin
        byte_t a0, a1, a2, a3, all;
        for (int c = 0; c < 4; c++)
        begin
            a0  = t[4 * c];
            a1  = t[4 * c + 1];
            a2  = t[4 * c + 2];
            a3  = t[4 * c + 3];
            all = a0 ^ a1 ^ a2 ^ a3;
            if (last)
            begin
                m[4 * c]     = a0;
                m[4 * c + 1] = a1;
                m[4 * c + 2] = a2;
                m[4 * c + 3] = a3;
            end
            else
            begin
                m[4 * c]     = a0 ^ all ^ xtime(a0 ^ a1);
                m[4 * c + 1] = a1 ^ all ^ xtime(a1 ^ a2);
                m[4 * c + 2] = a2 ^ all ^ xtime(a2 ^ a3);
                m[4 * c + 3] = a3 ^ all ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            res[8 * i +: 8] = m[i] ^ rk[8 * i +: 8];
        end
    end

endmodule

[hw/rtl/a256c_keyexp.sv]
// iterative key schedule: one 128-bit round key per cycle from a two-key window
`timescale 1ns / 1ps
module a256c_keyexp
    import a256c_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [255:0] key,
    output rk_wr_t       wr
);

    logic       busy_reg, busy_next;
    logic [3:0] k_reg, k_next;
    block_t     lo_reg, lo_next;
    block_t     hi_reg, hi_next;
    block_t     gen;
    logic [31:0] f;
    logic [31:0] w3;

    // next round key from the window (index k + 2)
    always_comb
    begin
        w3 = hi_reg[127:96];
        if (!k_reg[0])
        begin
            f[7:0]   = SBOX[w3[15:8]] ^ RCON[k_reg[3:1]];
            f[15:8]  = SBOX[w3[23:16]];
            f[23:16] = SBOX[w3[31:24]];
            f[31:24] = SBOX[w3[7:0]];
        end
        else
        begin
            f[7:0]   = SBOX[w3[7:0]];
            f[15:8]  = SBOX[w3[15:8]];
            f[23:16] = SBOX[w3[23:16]];
            f[31:24] = SBOX[w3[31:24]];
        end
        gen[31:0]   = lo_reg[31:0] ^ f;
        gen[63:32]  = lo_reg[63:32] ^ gen[31:0];
        gen[95:64]  = lo_reg[95:64] ^ gen[63:32];
        gen[127:96] = lo_reg[127:96] ^ gen[95:64];
    end

    // sequencing
    always_comb
    begin
        busy_next = busy_reg;
        k_next    = k_reg;
        lo_next   = lo_reg;
        hi_next   = hi_reg;
        if (start)
        begin
            busy_next = 1'b1;
            k_next    = '0;
            lo_next   = key[127:0];
            hi_next   = key[255:128];
        end
        else if (busy_reg)
        begin
            lo_next = hi_reg;
            hi_next = gen;
            k_next  = k_reg + 4'd1;
            if (k_reg == 4'(ROUNDS))
            begin
                busy_next = 1'b0;
            end
        end
    end

    assign wr.we   = busy_reg;
    assign wr.last = busy_reg && (k_reg == 4'(ROUNDS));
    assign wr.idx  = k_reg;
    assign wr.data = lo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            k_reg    <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
    end

endmodule

[hw/rtl/aes256_ctr_keystream.sv]
// top level: aes-256 ctr keystream generator with byte cache and shared round unit
//
// channel  direction  handshake             word
// in       input      in_valid / in_stall   in_word_t (restart, request_bytes)
// out      output     out_valid / out_stall out_word_t (stream_lo, stream_hi, byte_count)
// cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// a word served from the cache goes through load and finish; one that needs a new
// block goes through load, passes through the single round unit, and finish.
// a restart word first runs the key schedule, one round key per cycle.
// reset clears the counter and the cache; round keys are valid after a restart.
// one word is in flight at a time; a finished word waits in the output register
// while the next word is accepted, and finish waits only if that register is full and stalled.
`timescale 1ns / 1ps
module aes256_ctr_keystream
    import a256c_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_word_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_word_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    state_t      state_reg, state_next;
    logic [63:0] key0_reg, key1_reg, key2_reg, key3_reg, nlo_reg, nhi_reg;
    block_t      ctr_reg, ctr_next;
    block_t      cache_reg, cache_next;
    logic [4:0]  left_reg, left_next;
    logic [3:0]  pos_reg, pos_next;
    logic [4:0]  want_reg, want_next;
    logic [3:0]  round_reg, round_next;
    block_t      st_reg, st_next;
    logic        out_valid_reg, out_valid_next;
    out_word_t   out_reg, out_next;
    block_t      rk_mem [ROUNDS + 1];
    block_t      rk_rd;
    block_t      round_res;
    block_t      ctr_st;
    block_t      res;
    logic [4:0]  take, rest;
    logic        accept, kx_start;
    rk_wr_t      kx_wr;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg <= '0;
            key1_reg <= '0;
            key2_reg <= '0;
            key3_reg <= '0;
            nlo_reg  <= '0;
            nhi_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_KEY_W0:   key0_reg <= cfg_data;
                CFG_KEY_W1:   key1_reg <= cfg_data;
                CFG_KEY_W2:   key2_reg <= cfg_data;
                CFG_KEY_W3:   key3_reg <= cfg_data;
                CFG_NONCE_LO: nlo_reg  <= cfg_data;
                CFG_NONCE_HI: nhi_reg  <= cfg_data;
                default:      ;
            endcase
        end
    end

    // key schedule and round key store
    a256c_keyexp u_keyexp (
        .clk   (clk),
        .rst_n (rst_n),
        .start (kx_start),
        .key   ({key3_reg, key2_reg, key1_reg, key0_reg}),
        .wr    (kx_wr)
    );

    always_ff @(posedge clk)
    begin
        if (kx_wr.we)
        begin
            rk_mem[kx_wr.idx] <= kx_wr.data;
        end
    end

    assign rk_rd = rk_mem[(state_reg == ST_PREP) ? 4'd0 : round_reg];

    // shared round unit
    a256c_round u_round (
        .st   (st_reg),
        .rk   (rk_rd),
        .last (round_reg == 4'(ROUNDS)),
        .res  (round_res)
    );

    // counter bytes in cipher order, byte 0 most significant
    always_comb
    begin
        for (int i = 0; i < BLOCK_BYTES; i++)
        begin
            ctr_st[8 * i +: 8] = ctr_reg[127 - 8 * i -: 8];
        end
    end

    // split of the request between cache and fresh block
    assign take = (want_reg < left_reg) ? want_reg : left_reg;
    assign rest = want_reg - take;

    // result assembly
    always_comb
    begin
        logic [4:0] d;
        logic [3:0] ci;
        for (int i = 0; i < BLOCK_BYTES; i++)
        begin
            d  = 5'(i) - take;
            ci = pos_reg + 4'(i);
            if (5'(i) < take)
            begin
                res[8 * i +: 8] = cache_reg[8 * ci +: 8];
            end
            else if (5'(i) < want_reg)
            begin
                res[8 * i +: 8] = st_reg[8 * d[3:0] +: 8];
            end
            else
            begin
                res[8 * i +: 8] = 8'h00;
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        ctr_next       = ctr_reg;
        cache_next     = cache_reg;
        left_next      = left_reg;
        pos_next       = pos_reg;
        want_next      = want_reg;
        round_next     = round_reg;
        st_next        = st_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        kx_start       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (in_data.request_bytes != 5'd0))
                begin
                    want_next = in_data.request_bytes[4] ? 5'(BLOCK_BYTES)
                                                         : in_data.request_bytes;
                    if (in_data.restart)
                    begin
                        ctr_next   = {nlo_reg, nhi_reg};
                        left_next  = '0;
                        pos_next   = '0;
                        kx_start   = 1'b1;
                        state_next = ST_KEYX;
                    end
                    else
                    begin
                        state_next = ST_PREP;
                    end
                end
            end
            ST_KEYX:
            begin
                if (kx_wr.last)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                if (rest != 5'd0)
                begin
                    st_next    = ctr_st ^ rk_rd;
                    round_next = 4'd1;
                    state_next = ST_ENC;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_ENC:
            begin
                st_next    = round_res;
                round_next = round_reg + 4'd1;
                if (round_reg == 4'(ROUNDS))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next      = 1'b1;
                    out_next.stream_lo  = res[63:0];
                    out_next.stream_hi  = res[127:64];
                    out_next.byte_count = want_reg;
                    pos_next            = pos_reg + take[3:0];
                    left_next           = left_reg - take;
                    if (rest != 5'd0)
                    begin
                        ctr_next = ctr_reg + 128'd1;
                        if (rest != 5'(BLOCK_BYTES))
                        begin
                            cache_next = st_reg;
                            pos_next   = rest[3:0];
                            left_next  = 5'(BLOCK_BYTES) - rest;
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ctr_reg       <= '0;
            left_reg      <= '0;
            pos_reg       <= '0;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ctr_reg       <= ctr_next;
            left_reg      <= left_next;
            pos_reg       <= pos_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cache_reg <= cache_next;
        want_reg  <= want_next;
        st_reg    <= st_next;
        out_reg   <= out_next;
    end

    // checks
    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ENC) |-> (round_reg >= 4'd1 && round_reg <= 4'(ROUNDS)))
        else $error("round counter out of range");

    a_cache_bound: assert property (@(posedge clk) disable iff (!rst_n)
        left_reg < 5'(BLOCK_BYTES))
        else $error("cache holds more than a block less one byte");

    a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid_reg) |-> $past(!out_stall))
        else $error("result word dropped while stalled");

    a_kx_state: assert property (@(posedge clk) disable iff (!rst_n)
        kx_wr.last |-> (state_reg == ST_KEYX))
        else $error("key schedule finished outside key expansion");

endmodule
